// ===== hdl/csufe_pkg.sv =====
// ----------------------------------------------------------------------------
// csufe_pkg
// Shared codes, types and frame helpers for the gas-sensor UART frame engine.
// ----------------------------------------------------------------------------
package csufe_pkg;

    localparam int unsigned PACKET_BYTES = 9;
    localparam int unsigned TAIL_BYTES   = PACKET_BYTES - 1;

    // input commands
    localparam logic [3:0] CMD_READ    = 4'd0;
    localparam logic [3:0] CMD_ABC_ON  = 4'd1;
    localparam logic [3:0] CMD_ABC_OFF = 4'd2;
    localparam logic [3:0] CMD_ZERO    = 4'd3;
    localparam logic [3:0] CMD_SPAN    = 4'd4;
    localparam logic [3:0] CMD_RANGE   = 4'd5;
    localparam logic [3:0] CMD_RX      = 4'd6;
    localparam logic [3:0] CMD_TICK    = 4'd7;
    localparam logic [3:0] CMD_TIMEOUT = 4'd8;

    // request kinds as held in the active op register
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_ABC_ON  = 3'd1;
    localparam logic [2:0] OP_ABC_OFF = 3'd2;
    localparam logic [2:0] OP_ZERO    = 3'd3;
    localparam logic [2:0] OP_SPAN    = 3'd4;
    localparam logic [2:0] OP_RANGE   = 3'd5;

    // completion status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FRAME = 3'd1;
    localparam logic [2:0] ST_NO_RESP   = 3'd2;
    localparam logic [2:0] ST_SPAN_REJ  = 3'd3;
    localparam logic [2:0] ST_NOT_READY = 3'd4;

    // frame bytes
    localparam logic [7:0] BYTE_START  = 8'hFF;
    localparam logic [7:0] BYTE_ADDR   = 8'h01;
    localparam logic [7:0] OPC_READ    = 8'h86;
    localparam logic [7:0] OPC_ABC     = 8'h79;
    localparam logic [7:0] BYTE_ABC_ON = 8'hA0;
    localparam logic [7:0] OPC_ZERO    = 8'h87;
    localparam logic [7:0] OPC_SPAN    = 8'h88;
    localparam logic [7:0] OPC_RANGE   = 8'h99;

    localparam logic [15:0] PPM_BAD_FRAME = 16'h0101;
    localparam logic [19:0] MS_MAX        = 20'hFFFFF;

    localparam int unsigned REG_PREHEAT  = 0;
    localparam int unsigned REG_SPAN_MIN = 1;
    localparam int unsigned REG_SPAN_MAX = 2;

    // one result request from the control stage to the output stage
    typedef struct packed {
        logic        valid;   // this item causes a result
        logic        frame;   // 1: nine tx beats, 0: one done beat
        logic [2:0]  op;
        logic [15:0] value;
        logic [2:0]  status;
        logic [15:0] ppm;
    } t_req;

    typedef logic [TAIL_BYTES-1:0][7:0] t_tail;

    function automatic logic [7:0] opcode_of(input logic [2:0] op);
        logic [7:0] opc;
        unique case (op)
            OP_READ:    opc = OPC_READ;
            OP_ABC_ON:  opc = OPC_ABC;
            OP_ABC_OFF: opc = OPC_ABC;
            OP_ZERO:    opc = OPC_ZERO;
            OP_SPAN:    opc = OPC_SPAN;
            default:    opc = OPC_RANGE;
        endcase
        return opc;
    endfunction

endpackage

// ===== hdl/co2_sensor_uart_frame_engine_top.sv =====
// ----------------------------------------------------------------------------
// co2_sensor_uart_frame_engine_top
// Host-side engine for a 9-byte UART gas-sensor command/response protocol.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one command beat: a request
//   (read, auto-baseline on/off, zero cal, span cal, set range), a received
//   byte, a millisecond tick or a timeout. Output channel (o_out_valid /
//   i_out_stall) returns result beats: either a tx byte (o_tx_valid, with
//   o_tx_last on the ninth) or a completion (o_done_res, status, ppm).
//   Path: an accepted beat is held in the input register; its first result
//   is registered into the output register as the beat leaves it.
//   Throughput: one beat per cycle for commands giving zero or one result
//   while the receiver does not stall. A frame request holds the output
//   register for its tx beats; the input register holds the next beat and
//   the input channel stalls. When the receiver stalls, the output register
//   holds its beat, the input register fills and then o_in_stall rises.
//   Reset: all protocol state clears, the ms counter is zero (readings not
//   ready), registers return to preheat 180000 ms and span window 1000..5000.
//   Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once;
//   index 3 is ignored.
// ----------------------------------------------------------------------------
module co2_sensor_uart_frame_engine_top import csufe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_command,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [15:0] o_co2_ppm,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    logic [19:0] r_preheat_ms;
    logic [15:0] r_span_min;
    logic [15:0] r_span_max;

    t_req req;
    logic take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preheat_ms <= 20'd180000;
            r_span_min   <= 16'd1000;
            r_span_max   <= 16'd5000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 2'(REG_PREHEAT))  r_preheat_ms <= i_cfg_data;
            if (i_cfg_index == 2'(REG_SPAN_MIN)) r_span_min   <= i_cfg_data[15:0];
            if (i_cfg_index == 2'(REG_SPAN_MAX)) r_span_max   <= i_cfg_data[15:0];
        end
    end

    csufe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_rx_byte    (i_rx_byte),
        .i_preheat_ms (r_preheat_ms),
        .i_span_min   (r_span_min),
        .i_span_max   (r_span_max),
        .i_take       (take),
        .o_req        (req)
    );

    csufe_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_tx_last   (o_tx_last),
        .o_done_res  (o_done_res),
        .o_status    (o_status),
        .o_co2_ppm   (o_co2_ppm)
    );

endmodule

// ===== hdl/csufe_ctrl.sv =====
// ----------------------------------------------------------------------------
// csufe_ctrl
// Input register, command decode and protocol state (preheat, reply check).
// ----------------------------------------------------------------------------
module csufe_ctrl import csufe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_command,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_rx_byte,
    input  logic [19:0] i_preheat_ms,
    input  logic [15:0] i_span_min,
    input  logic [15:0] i_span_max,
    input  logic        i_take,
    output t_req        o_req
);

    logic        r_in_valid;
    logic [3:0]  r_cmd;
    logic [15:0] r_val;
    logic [7:0]  r_rx;

    logic        r_preheat_done, n_preheat_done;
    logic [19:0] r_ms_count,     n_ms_count;
    logic [2:0]  r_active_op,    n_active_op;
    logic        r_waiting,      n_waiting;
    logic [3:0]  r_rx_index,     n_rx_index;
    logic [7:0]  r_rx_sum,       n_rx_sum;
    logic        r_frame_ok,     n_frame_ok;
    logic [7:0]  r_read_hi,      n_read_hi;
    logic [7:0]  r_read_lo,      n_read_lo;

    logic adv;
    logic accept;
    logic pre_ok;
    logic ok_final;
    t_req req;

    assign adv        = r_in_valid && i_take;
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
            r_rx  <= i_rx_byte;
        end
    end

    assign pre_ok   = r_preheat_done || (r_ms_count > i_preheat_ms);
    assign ok_final = r_frame_ok && (r_rx == (8'd0 - r_rx_sum));

    // decode of the held item
    always_comb begin
        n_preheat_done = r_preheat_done;
        n_ms_count     = r_ms_count;
        n_active_op    = r_active_op;
        n_waiting      = r_waiting;
        n_rx_index     = r_rx_index;
        n_rx_sum       = r_rx_sum;
        n_frame_ok     = r_frame_ok;
        n_read_hi      = r_read_hi;
        n_read_lo      = r_read_lo;
        req            = '0;

        unique case (r_cmd)
            CMD_READ, CMD_ABC_ON, CMD_ABC_OFF, CMD_ZERO, CMD_SPAN, CMD_RANGE: begin
                req.valid = 1'b1;
                req.frame = 1'b1;
                req.op    = r_cmd[2:0];
                req.value = r_val;
                if (r_cmd == CMD_READ) begin
                    n_preheat_done = pre_ok;
                    req.value      = '0;
                    if (!pre_ok) begin
                        req.frame  = 1'b0;
                        req.status = ST_NOT_READY;
                    end
                end
                if (r_cmd == CMD_SPAN && (r_val < i_span_min || r_val > i_span_max)) begin
                    req.frame  = 1'b0;
                    req.status = ST_SPAN_REJ;
                end
                if (req.frame) begin
                    n_active_op = r_cmd[2:0];
                    n_waiting   = 1'b1;
                    n_rx_index  = '0;
                    n_rx_sum    = '0;
                    n_frame_ok  = 1'b1;
                    n_read_hi   = '0;
                    n_read_lo   = '0;
                end
            end
            CMD_RX: begin
                if (r_waiting) begin
                    if (r_rx_index == 4'd0) begin
                        if (r_rx != BYTE_START) n_frame_ok = 1'b0;
                        n_rx_index = r_rx_index + 4'd1;
                    end else if (r_rx_index < 4'(PACKET_BYTES - 1)) begin
                        if (r_rx_index == 4'd1 && r_rx != opcode_of(r_active_op))
                            n_frame_ok = 1'b0;
                        if (r_rx_index == 4'd2) n_read_hi = r_rx;
                        if (r_rx_index == 4'd3) n_read_lo = r_rx;
                        n_rx_sum   = r_rx_sum + r_rx;
                        n_rx_index = r_rx_index + 4'd1;
                    end else begin
                        // checksum byte closes the reply
                        n_waiting  = 1'b0;
                        n_rx_index = '0;
                        n_frame_ok = ok_final;
                        req.valid  = 1'b1;
                        if (ok_final) begin
                            req.status = ST_OK;
                            req.ppm    = (r_active_op == OP_READ) ? {r_read_hi, r_read_lo}
                                                                  : 16'd0;
                        end else begin
                            req.status = ST_BAD_FRAME;
                            req.ppm    = PPM_BAD_FRAME;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_ms_count < MS_MAX) n_ms_count = r_ms_count + 20'd1;
            end
            CMD_TIMEOUT: begin
                if (r_waiting) begin
                    n_waiting  = 1'b0;
                    n_rx_index = '0;
                    req.valid  = 1'b1;
                    req.status = ST_NO_RESP;
                end
            end
            default: begin
            end
        endcase

        if (!adv) req.valid = 1'b0;
    end

    assign o_req = req;

    // protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preheat_done <= 1'b0;
            r_ms_count     <= '0;
            r_active_op    <= OP_READ;
            r_waiting      <= 1'b0;
            r_rx_index     <= '0;
            r_rx_sum       <= '0;
            r_frame_ok     <= 1'b1;
            r_read_hi      <= '0;
            r_read_lo      <= '0;
        end else if (adv) begin
            r_preheat_done <= n_preheat_done;
            r_ms_count     <= n_ms_count;
            r_active_op    <= n_active_op;
            r_waiting      <= n_waiting;
            r_rx_index     <= n_rx_index;
            r_rx_sum       <= n_rx_sum;
            r_frame_ok     <= n_frame_ok;
            r_read_hi      <= n_read_hi;
            r_read_lo      <= n_read_lo;
        end
    end

endmodule

// ===== hdl/csufe_out.sv =====
// ----------------------------------------------------------------------------
// csufe_out
// Frame builder, tail shift register and result output register.
// ----------------------------------------------------------------------------
module csufe_out import csufe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    output logic        o_take,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [15:0] o_co2_ppm
);

    logic        r_out_valid;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_tx_last;
    logic        r_done;
    logic [2:0]  r_status;
    logic [15:0] r_ppm;
    t_tail       r_tail;
    logic [3:0]  r_tail_cnt;

    logic        out_free;
    t_tail       frm;
    logic [7:0]  sum;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = out_free && (r_tail_cnt == 4'd0);

    // bytes 1..8 of the frame; byte 0 is always the start byte
    always_comb begin
        frm    = '0;
        frm[0] = BYTE_ADDR;
        frm[1] = opcode_of(i_req.op);
        if (i_req.op == OP_ABC_ON) frm[2] = BYTE_ABC_ON;
        if (i_req.op == OP_SPAN) begin
            frm[2] = i_req.value[15:8];
            frm[3] = i_req.value[7:0];
        end
        if (i_req.op == OP_RANGE) begin
            frm[5] = i_req.value[15:8];
            frm[6] = i_req.value[7:0];
        end
        sum = frm[0] + frm[1] + frm[2] + frm[3] + frm[4] + frm[5] + frm[6];
        frm[TAIL_BYTES-1] = 8'd0 - sum;
    end

    // output register valid and tail count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tail_cnt  <= '0;
        end else if (out_free) begin
            if (r_tail_cnt != 4'd0) begin
                r_out_valid <= 1'b1;
                r_tail_cnt  <= r_tail_cnt - 4'd1;
            end else if (i_req.valid) begin
                r_out_valid <= 1'b1;
                r_tail_cnt  <= i_req.frame ? 4'(TAIL_BYTES) : 4'd0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload and tail bytes
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_tail_cnt != 4'd0) begin
                r_tx_valid <= 1'b1;
                r_tx_byte  <= r_tail[0];
                r_tx_last  <= (r_tail_cnt == 4'd1);
                r_done     <= 1'b0;
                r_status   <= ST_OK;
                r_ppm      <= '0;
                r_tail     <= {8'd0, r_tail[TAIL_BYTES-1:1]};
            end else if (i_req.valid) begin
                if (i_req.frame) begin
                    r_tx_valid <= 1'b1;
                    r_tx_byte  <= BYTE_START;
                    r_tx_last  <= 1'b0;
                    r_done     <= 1'b0;
                    r_status   <= ST_OK;
                    r_ppm      <= '0;
                    r_tail     <= frm;
                end else begin
                    r_tx_valid <= 1'b0;
                    r_tx_byte  <= '0;
                    r_tx_last  <= 1'b0;
                    r_done     <= 1'b1;
                    r_status   <= i_req.status;
                    r_ppm      <= i_req.ppm;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_tx_last   = r_tx_last;
    assign o_done_res  = r_done;
    assign o_status    = r_status;
    assign o_co2_ppm   = r_ppm;

endmodule
